/* rtl/depth_priority_view_blend_core_assert.svh */
// Assertion macros for the view blend core.
// Each macro expects clk and rst_n in scope.
`ifndef DEPTH_PRIORITY_VIEW_BLEND_CORE_ASSERT_SVH
`define DEPTH_PRIORITY_VIEW_BLEND_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DPVB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpvb assertion failed");
`define DPVB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpvb assertion failed");
`else
`define DPVB_ASSERT_IMPL(label, ante, cons)
`define DPVB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/dpvb_pkg.sv */
`default_nettype none

package dpvb_pkg;

  localparam int MAX_CAMERAS = 16;

  localparam int RANK_W  = 4;
  localparam int COLOR_W = 24;
  localparam int DEPTH_W = 31;
  localparam int MASK_W  = 8;
  localparam int THR_W   = 8;

  // sample count must hold MAX_CAMERAS itself
  localparam int CNT_W  = $clog2(MAX_CAMERAS + 1);
  localparam int SUM_W  = $clog2(MAX_CAMERAS * 255 + 1);
  localparam int PROD_W = THR_W + CNT_W;

  localparam logic [THR_W-1:0]  THR_RESET    = 8'd127;
  localparam logic [MASK_W-1:0] MASK_VISIBLE = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_HIDDEN  = 8'h00;

endpackage

`default_nettype wire

/* rtl/dpvb_if.sv */
`default_nettype none

interface dpvb_in_if;
  import dpvb_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  cam_rank;
  logic [COLOR_W-1:0] sample_color;
  logic [DEPTH_W-1:0] sample_depth;
  logic [MASK_W-1:0]  sample_mask;
  logic               last_camera;

  modport source (output valid, cam_rank, sample_color, sample_depth, sample_mask,
                  last_camera, input ready);
  modport sink   (input valid, cam_rank, sample_color, sample_depth, sample_mask,
                  last_camera, output ready);
endinterface

interface dpvb_out_if;
  import dpvb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_color;
  logic [DEPTH_W-1:0] out_depth;
  logic [MASK_W-1:0]  out_mask;

  modport source (output valid, out_color, out_depth, out_mask, input ready);
  modport sink   (input valid, out_color, out_depth, out_mask, output ready);
endinterface

interface dpvb_cfg_if;
  import dpvb_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] visibility_threshold;

  modport source (output valid, visibility_threshold, input ready);
  modport sink   (input valid, visibility_threshold, output ready);
endinterface

`default_nettype wire

/* rtl/depth_priority_view_blend_core.sv */
// Depth-priority view blend: composites one output pixel from a stream of
// per-camera samples (rank, color, depth, mask), the last one flagged.
// Channels: in_ch carries camera samples, out_ch one blended pixel per
// closed pixel, cfg_ch writes the visibility threshold (always ready).
// Throughput: one sample per cycle, set by the accumulate/compare stage
// between the input and output registers, unless a last sample is held back.
// A last-camera sample passes the input register, then the result register,
// which raises out_ch.valid.
// The pixel is visible when mask sum >= threshold * sample count; the winner
// is the smallest nonzero depth, ties to the lowest rank, else the rank-0 sample.
// Samples past MAX_CAMERAS in one pixel are dropped; their last flag still
// closes the pixel.
// Reset: threshold returns to 127, pixel accumulators clear, both registers
// empty. Stall: while out_ch.ready is low and a result waits, non-last samples
// keep flowing; a last sample holds in the input register until the result
// register frees, and in_ch.ready drops only then.
// Threshold is read when the pixel closes; write it only while idle.
`default_nettype none

`include "depth_priority_view_blend_core_assert.svh"

module depth_priority_view_blend_core
  import dpvb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  dpvb_in_if.sink     in_ch,
  dpvb_out_if.source  out_ch,
  dpvb_cfg_if.sink    cfg_ch
);

  // config
  logic [THR_W-1:0] thr_r;

  // input register
  logic               s1_valid_r;
  logic [RANK_W-1:0]  s1_rank_r;
  logic [COLOR_W-1:0] s1_color_r;
  logic [DEPTH_W-1:0] s1_depth_r;
  logic [MASK_W-1:0]  s1_mask_r;
  logic               s1_last_r;

  // per-pixel accumulators
  logic [SUM_W-1:0]   sum_r,        sum_nxt;
  logic [CNT_W-1:0]   cnt_r,        cnt_nxt;
  logic               have_r,       have_nxt;
  logic [DEPTH_W-1:0] best_depth_r, best_depth_nxt;
  logic [RANK_W-1:0]  best_rank_r,  best_rank_nxt;
  logic [COLOR_W-1:0] best_color_r, best_color_nxt;
  logic [COLOR_W-1:0] fb_color_r,   fb_color_nxt;
  logic [DEPTH_W-1:0] fb_depth_r,   fb_depth_nxt;

  // result register
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic [MASK_W-1:0]  out_mask_r,  out_mask_nxt;

  logic              out_free;
  logic              s1_adv;
  logic              out_load;
  logic              take;
  logic              better;
  logic [PROD_W-1:0] need;
  logic              visible;

  // handshake: a last sample waits only for the result register
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign out_load = s1_adv && s1_last_r;

  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_color = out_color_r;
  assign out_ch.out_depth = out_depth_r;
  assign out_ch.out_mask  = out_mask_r;

  // accumulate / compare
  assign take   = cnt_r < CNT_W'(MAX_CAMERAS);
  assign better = !have_r || (s1_depth_r < best_depth_r) ||
                  ((s1_depth_r == best_depth_r) && (s1_rank_r < best_rank_r));

  always_comb begin
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    have_nxt       = have_r;
    best_depth_nxt = best_depth_r;
    best_rank_nxt  = best_rank_r;
    best_color_nxt = best_color_r;
    fb_color_nxt   = fb_color_r;
    fb_depth_nxt   = fb_depth_r;
    if (take) begin
      sum_nxt = sum_r + SUM_W'(s1_mask_r);
      cnt_nxt = cnt_r + CNT_W'(1);
      if (s1_rank_r == '0) begin
        fb_color_nxt = s1_color_r;
        fb_depth_nxt = s1_depth_r;
      end
      if (s1_depth_r != '0) begin
        if (better) begin
          best_depth_nxt = s1_depth_r;
          best_rank_nxt  = s1_rank_r;
          best_color_nxt = s1_color_r;
        end
        have_nxt = 1'b1;
      end
    end
  end

  // visibility: sum >= threshold * count, count includes this sample
  assign need    = PROD_W'(thr_r) * PROD_W'(cnt_nxt);
  assign visible = PROD_W'(sum_nxt) >= need;

  always_comb begin
    out_color_nxt = '0;
    out_depth_nxt = '0;
    out_mask_nxt  = MASK_HIDDEN;
    if (visible) begin
      out_mask_nxt = MASK_VISIBLE;
      if (have_nxt) begin
        out_color_nxt = best_color_nxt;
        out_depth_nxt = best_depth_nxt;
      end else begin
        out_color_nxt = fb_color_nxt;
        out_depth_nxt = fb_depth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THR_RESET;
      s1_valid_r   <= 1'b0;
      sum_r        <= '0;
      cnt_r        <= '0;
      have_r       <= 1'b0;
      best_depth_r <= '0;
      best_rank_r  <= '0;
      best_color_r <= '0;
      fb_color_r   <= '0;
      fb_depth_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.visibility_threshold;
      end

      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_last_r) begin
          // pixel closes: start the next one clean
          sum_r        <= '0;
          cnt_r        <= '0;
          have_r       <= 1'b0;
          best_depth_r <= '0;
          best_rank_r  <= '0;
          best_color_r <= '0;
          fb_color_r   <= '0;
          fb_depth_r   <= '0;
        end else begin
          sum_r        <= sum_nxt;
          cnt_r        <= cnt_nxt;
          have_r       <= have_nxt;
          best_depth_r <= best_depth_nxt;
          best_rank_r  <= best_rank_nxt;
          best_color_r <= best_color_nxt;
          fb_color_r   <= fb_color_nxt;
          fb_depth_r   <= fb_depth_nxt;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_rank_r  <= in_ch.cam_rank;
      s1_color_r <= in_ch.sample_color;
      s1_depth_r <= in_ch.sample_depth;
      s1_mask_r  <= in_ch.sample_mask;
      s1_last_r  <= in_ch.last_camera;
    end
    if (out_load) begin
      out_color_r <= out_color_nxt;
      out_depth_r <= out_depth_nxt;
      out_mask_r  <= out_mask_nxt;
    end
  end

  `DPVB_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_CAMERAS))
  `DPVB_ASSERT_IMPL(a_sum_bound, 1'b1,
                    PROD_W'(sum_r) <= PROD_W'(255) * PROD_W'(cnt_r))
  `DPVB_ASSERT_NEXT(a_close_clears, out_load, cnt_r == '0 && !have_r && out_valid_r)
  `DPVB_ASSERT_IMPL(a_mask_code, out_valid_r,
                    out_mask_r == MASK_VISIBLE || out_mask_r == MASK_HIDDEN)
  `DPVB_ASSERT_IMPL(a_hidden_zero, out_valid_r && out_mask_r == MASK_HIDDEN,
                    out_color_r == '0 && out_depth_r == '0)

endmodule

`default_nettype wire

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpvb_pkg::*;

  // Quiet cycles (no handshake on any channel) before the run is declared hung.
  // The longest legal quiet stretch is the forced receiver hold-off below plus
  // the drain wait at each phase boundary.
  localparam int WATCHDOG_LIMIT = 2000;
  // Closing sample passes the input register, then the result register; leave some margin.
  localparam int DRAIN_CYCLES   = 8;
  // Forced receiver hold-off, long enough to back the block up into in_ch.
  localparam int LONG_STALL     = 150;
  localparam int PHASE_ITEMS    = 100;

  localparam logic [DEPTH_W-1:0] DEPTH_NONE    = '0;
  localparam logic [DEPTH_W-1:0] DEPTH_ONE_F   = 31'h3F800000;
  localparam logic [DEPTH_W-1:0] DEPTH_TWO_F   = 31'h40000000;
  localparam logic [DEPTH_W-1:0] DEPTH_HALF_F  = 31'h3F000000;
  localparam logic [DEPTH_W-1:0] DEPTH_INF     = 31'h7F800000;
  localparam logic [DEPTH_W-1:0] DEPTH_PAST_INF = 31'h7F800001;
  localparam logic [DEPTH_W-1:0] DEPTH_ALL_ONES = 31'h7FFFFFFF;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;
    logic [MASK_W-1:0]  mask;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;
    logic [MASK_W-1:0]  mask;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  dpvb_in_if  in_ch();
  dpvb_out_if out_ch();
  dpvb_cfg_if cfg_ch();

  depth_priority_view_blend_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Camera samples waiting to go out; the head is what in_ch currently offers.
  sample_t sample_queue[$];
  // Blended pixels still owed by the block, oldest first.
  pixel_t  expected_pixels[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_request  = 0;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  // Shadow of the block's pixel accumulators and its threshold register.
  logic [THR_W-1:0]   threshold_copy = THR_RESET;
  logic [SUM_W-1:0]   acc_mask_sum   = '0;
  logic [CNT_W-1:0]   acc_count      = '0;
  logic               acc_have_depth = 1'b0;
  logic [DEPTH_W-1:0] win_depth      = '0;
  logic [RANK_W-1:0]  win_rank       = '0;
  logic [COLOR_W-1:0] win_color      = '0;
  logic [COLOR_W-1:0] rank0_color    = '0;
  logic [DEPTH_W-1:0] rank0_depth    = '0;

  // Fold one accepted camera sample into the pixel; on the last camera, close
  // the pixel and queue the blended result.
  task automatic composite_sample(sample_t s);
    pixel_t px;
    // samples past MAX_CAMERAS are dropped, but their last flag still counts
    if (acc_count < MAX_CAMERAS) begin
      acc_mask_sum = acc_mask_sum + SUM_W'(s.mask);
      acc_count    = acc_count + CNT_W'(1);
      if (s.rank == 0) begin
        rank0_color = s.color;
        rank0_depth = s.depth;
      end
      if (s.depth != DEPTH_NONE) begin
        // smallest raw depth wins, equal depth goes to the lower rank
        if (!acc_have_depth || s.depth < win_depth ||
            (s.depth == win_depth && s.rank < win_rank)) begin
          win_depth = s.depth;
          win_rank  = s.rank;
          win_color = s.color;
        end
        acc_have_depth = 1'b1;
      end
    end
    if (s.last) begin
      if (int'(acc_mask_sum) >= int'(threshold_copy) * int'(acc_count)) begin
        px.color = acc_have_depth ? win_color : rank0_color;
        px.depth = acc_have_depth ? win_depth : rank0_depth;
        px.mask  = MASK_VISIBLE;
      end else begin
        px.color = '0;
        px.depth = '0;
        px.mask  = MASK_HIDDEN;
      end
      expected_pixels = {expected_pixels, px};
      acc_mask_sum   = '0;
      acc_count      = '0;
      acc_have_depth = 1'b0;
      win_depth      = '0;
      win_rank       = '0;
      win_color      = '0;
      rank0_color    = '0;
      rank0_depth    = '0;
    end
  endtask

  // Sample driver: offer the queue head, hold it until accepted, idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        composite_sample(sample_queue.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid        <= 1'b1;
          in_ch.cam_rank     <= sample_queue[0].rank;
          in_ch.sample_color <= sample_queue[0].color;
          in_ch.sample_depth <= sample_queue[0].depth;
          in_ch.sample_mask  <= sample_queue[0].mask;
          in_ch.last_camera  <= sample_queue[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted pixel against the oldest expectation,
  // and drive ready with random stalls or a requested long hold-off.
  always @(posedge clk) begin : result_monitor
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel with no expectation: color %h depth %h mask %h",
                 out_ch.out_color, out_ch.out_depth, out_ch.out_mask);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.out_color !== want.color) begin
            $error("out_color: expected %h, got %h", want.color, out_ch.out_color);
            mismatch_count++;
          end
          if (out_ch.out_depth !== want.depth) begin
            $error("out_depth: expected %h, got %h", want.depth, out_ch.out_depth);
            mismatch_count++;
          end
          if (out_ch.out_mask !== want.mask) begin
            $error("out_mask: expected %h, got %h", want.mask, out_ch.out_mask);
            mismatch_count++;
          end
        end
      end
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $error("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_sample(logic [RANK_W-1:0] rank, logic [COLOR_W-1:0] color,
                            logic [DEPTH_W-1:0] depth, logic [MASK_W-1:0] mask,
                            logic last);
    sample_t s;
    s.rank  = rank;
    s.color = color;
    s.depth = depth;
    s.mask  = mask;
    s.last  = last;
    sample_queue = {sample_queue, s};
  endtask

  function automatic sample_t random_sample(logic last);
    sample_t s;
    int      m;
    s.rank  = ($urandom_range(3) == 0) ? '0 : RANK_W'($urandom_range(15));
    case ($urandom_range(15))
      0:       s.color = '0;
      1:       s.color = '1;
      default: s.color = COLOR_W'($urandom());
    endcase
    // plenty of no-depth samples and repeated depths so ties really happen
    case ($urandom_range(7))
      0, 1:    s.depth = DEPTH_NONE;
      2:       s.depth = $urandom_range(1) ? DEPTH_ONE_F : DEPTH_TWO_F;
      3: begin
        case ($urandom_range(3))
          0:       s.depth = DEPTH_INF;
          1:       s.depth = DEPTH_PAST_INF;
          2:       s.depth = DEPTH_ALL_ONES;
          default: s.depth = 31'd1;
        endcase
      end
      default: s.depth = DEPTH_W'($urandom());
    endcase
    // bias masks toward the current threshold to hit the visibility boundary
    case ($urandom_range(9))
      0, 1:    s.mask = '1;
      2:       s.mask = '0;
      3: begin
        m = int'(threshold_copy) + $urandom_range(2) - 1;
        if (m < 0) m = 0;
        if (m > 255) m = 255;
        s.mask = MASK_W'(m);
      end
      default: s.mask = MASK_W'($urandom());
    endcase
    s.last = last;
    return s;
  endfunction

  // Whole pixels of random length, mostly short, a few at or past MAX_CAMERAS.
  task automatic queue_random_pixels(int n_items);
    int placed;
    int len;
    int pick;
    placed = 0;
    while (placed < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6)       len = $urandom_range(MAX_CAMERAS + 1, MAX_CAMERAS + 4);
      else if (pick < 10) len = MAX_CAMERAS;
      else if (pick < 25) len = $urandom_range(7, MAX_CAMERAS - 1);
      else                len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        sample_queue = {sample_queue, random_sample(i == len - 1)};
      end
      placed += len;
    end
  endtask

  // Block idle: every sample accepted, every pixel back, pipeline drained.
  task automatic wait_for_idle();
    while (sample_queue.size() != 0 || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid                <= 1'b1;
    cfg_ch.visibility_threshold <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    threshold_copy = value;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n                       = 1'b0;
    in_ch.valid                 = 1'b0;
    in_ch.cam_rank              = '0;
    in_ch.sample_color          = '0;
    in_ch.sample_depth          = '0;
    in_ch.sample_mask           = '0;
    in_ch.last_camera           = 1'b0;
    out_ch.ready                = 1'b0;
    cfg_ch.valid                = 1'b0;
    cfg_ch.visibility_threshold = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset threshold of 127, no idling.
    // lone rank-0 sample without depth: fallback color, visible
    add_sample(4'd0, 24'hFFFFFF, DEPTH_NONE, 8'd255, 1'b1);
    // mask sum exactly threshold * count; infinity beats the larger patterns
    add_sample(4'd15, 24'h000000, DEPTH_ALL_ONES, 8'd128, 1'b0);
    add_sample(4'd1, 24'h123456, DEPTH_INF, 8'd127, 1'b0);
    add_sample(4'd0, 24'hABCDEF, DEPTH_PAST_INF, 8'd126, 1'b1);
    // equal depths: lower rank wins, equal rank keeps the earlier sample
    add_sample(4'd3, 24'h111111, DEPTH_ONE_F, 8'd200, 1'b0);
    add_sample(4'd2, 24'h222222, DEPTH_ONE_F, 8'd200, 1'b0);
    add_sample(4'd2, 24'h333333, DEPTH_ONE_F, 8'd200, 1'b0);
    add_sample(4'd5, 24'h444444, DEPTH_TWO_F, 8'd200, 1'b1);
    // a tie later superseded by a smaller depth must not come back
    add_sample(4'd4, 24'h0000AA, DEPTH_TWO_F, 8'd255, 1'b0);
    add_sample(4'd1, 24'h0000BB, DEPTH_TWO_F, 8'd255, 1'b0);
    add_sample(4'd6, 24'h0000CC, DEPTH_HALF_F, 8'd255, 1'b1);
    add_sample(4'd2, 24'h000055, DEPTH_HALF_F, 8'd255, 1'b0);
    add_sample(4'd0, 24'h000066, DEPTH_TWO_F, 8'd255, 1'b1);
    // no rank-0 sample and no depth: zero color and depth, still visible
    add_sample(4'd4, 24'h777777, DEPTH_NONE, 8'd255, 1'b0);
    add_sample(4'd9, 24'h888888, DEPTH_NONE, 8'd200, 1'b1);
    // several rank-0 samples: the last one is the fallback
    add_sample(4'd0, 24'h0A0B0C, DEPTH_NONE, 8'd255, 1'b0);
    add_sample(4'd0, 24'h0D0E0F, DEPTH_NONE, 8'd255, 1'b1);
    // below threshold: everything zero
    add_sample(4'd0, 24'hFFFFFF, 31'd1, 8'd0, 1'b0);
    add_sample(4'd1, 24'hFFFFFF, DEPTH_ALL_ONES, 8'd126, 1'b1);
    // single sample with the all-ones depth pattern
    add_sample(4'd15, 24'h000000, DEPTH_ALL_ONES, 8'd127, 1'b1);
    wait_for_idle();

    // Threshold 0, no idling. The receiver holds off for a long stretch
    // while samples keep coming, so the block backs up and drops in_ch.ready.
    write_threshold(8'd0);
    @(negedge clk);
    stall_request = LONG_STALL;
    queue_random_pixels(PHASE_ITEMS);
    wait_for_idle();

    // Threshold 255, sender idles often.
    write_threshold(8'd255);
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    queue_random_pixels(PHASE_ITEMS);
    wait_for_idle();

    // Mid-range threshold, receiver stalls often.
    write_threshold(THR_W'($urandom_range(2, 254)));
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    queue_random_pixels(PHASE_ITEMS);
    wait_for_idle();

    // Threshold 1, light idling on both sides.
    write_threshold(8'd1);
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    queue_random_pixels(PHASE_ITEMS);
    wait_for_idle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
